### design/rtsp_pkg.sv
// ----------------------------------------------------------------------------
// rtsp_pkg
// Shared types, constants and codes for the ring tile-map scroll planner.
// ----------------------------------------------------------------------------
package rtsp_pkg;

    localparam int WORLD_TILES  = 512;
    localparam int VIEW_TILES   = 128;
    localparam int UPDATE_LIMIT = 8;
    localparam int CENTER_TILES = 64;

    localparam int WORLD_W = $clog2(WORLD_TILES);
    localparam int VIEW_W  = $clog2(VIEW_TILES);
    localparam int STEP_W  = WORLD_W + 1;
    localparam int CNT_W   = $clog2(UPDATE_LIMIT + 1);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_COL    = 2'd0,
        KIND_ROW    = 2'd1,
        KIND_NONE   = 2'd2,
        KIND_RELOAD = 2'd3
    } kind_t;

    typedef enum logic {
        CMD_INIT = 1'b0,
        CMD_MOVE = 1'b1
    } cmd_t;

    typedef enum logic {
        BK_IDLE,
        BK_RUN
    } bk_state_t;

    typedef struct packed {
        logic               command;
        logic signed [15:0] cam_x;
        logic signed [15:0] cam_y;
    } item_t;

    typedef struct packed {
        logic [1:0]         update_kind;
        logic [VIEW_W-1:0]  vram_line;
        logic [WORLD_W-1:0] src_x;
        logic [WORLD_W-1:0] src_y;
        logic signed [15:0] scroll_x;
        logic signed [15:0] scroll_y;
        logic [VIEW_W-1:0]  ring_left;
        logic [VIEW_W-1:0]  ring_top;
        logic               dropped;
        logic               last;
    } result_t;

    // One classified command as handed from the front to the back.
    typedef struct packed {
        logic               is_init;
        logic [WORLD_W-1:0] ox0;
        logic [WORLD_W-1:0] oy0;
        logic [VIEW_W-1:0]  rc0;
        logic [VIEW_W-1:0]  rr0;
        logic               col_neg;
        logic [WORLD_W-1:0] col_mag;
        logic               row_neg;
        logic [WORLD_W-1:0] row_mag;
        logic [WORLD_W-1:0] tx;
        logic [WORLD_W-1:0] ty;
        logic [VIEW_W-1:0]  rc_fin;
        logic [VIEW_W-1:0]  rr_fin;
        logic [15:0]        scroll_x;
        logic [15:0]        scroll_y;
        logic               dropped;
        logic [CNT_W-1:0]   total;
    } job_t;

endpackage

### design/ring_tilemap_scroll_planner_core.sv
// ----------------------------------------------------------------------------
// ring_tilemap_scroll_planner_core
// Plans ring-buffer column and row refills for a scrolling tile-map window.
// ----------------------------------------------------------------------------
// The command word is written into the job queue, taken into the back end's
// job register and its first result word then goes to the output register.
// A command gives n result words (1 to the update limit), one word per cycle
// while the output is free; the back end takes the next job after the last word.
// Reset clears the window origin, the ring origins, the job queue and the
// output valid flag; the block accepts words in the first cycle after reset.
module ring_tilemap_scroll_planner_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  rtsp_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_ready,
    output rtsp_pkg::result_t result
);

    logic           q_push;
    logic           q_pop;
    logic           q_full;
    logic           q_empty;
    rtsp_pkg::job_t push_job;
    rtsp_pkg::job_t head_job;

    rtsp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_job      (push_job)
    );

    rtsp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .pop      (q_pop),
        .head_job (head_job),
        .full     (q_full),
        .empty    (q_empty)
    );

    rtsp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_head       (head_job),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // A full reload is always the only word of its command.
    a_reload_single: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.update_kind == rtsp_pkg::KIND_RELOAD)
        |-> result.last && !result.dropped && (result.vram_line == '0))
        else $error("reload word is not a lone final word");

    // Dropped steps are flagged on the final word only.
    a_dropped_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.dropped |-> result.last)
        else $error("dropped flag on a word that is not final");

    // A command without steps yields one plain word.
    a_none_single: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.update_kind == rtsp_pkg::KIND_NONE)
        |-> result.last && !result.dropped)
        else $error("no-update word is not a lone final word");

    // The back end only takes a job that the queue holds.
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("job taken from an empty queue");

endmodule

### design/rtsp_front.sv
// ----------------------------------------------------------------------------
// rtsp_front
// Accepts command words, works out the wrapped tile deltas and the state after
// the whole command, updates the window state and queues a job for the back.
// ----------------------------------------------------------------------------
module rtsp_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  rtsp_pkg::item_t      item,
    input  logic                 q_full,
    output logic                 q_push,
    output rtsp_pkg::job_t       q_job
);

    logic [rtsp_pkg::WORLD_W-1:0] origin_x_reg, origin_x_next;
    logic [rtsp_pkg::WORLD_W-1:0] origin_y_reg, origin_y_next;
    logic [rtsp_pkg::VIEW_W-1:0]  ring_col_reg, ring_col_next;
    logic [rtsp_pkg::VIEW_W-1:0]  ring_row_reg, ring_row_next;

    logic signed [31:0]           cx_div;
    logic signed [31:0]           cy_div;
    logic [rtsp_pkg::WORLD_W-1:0] tx;
    logic [rtsp_pkg::WORLD_W-1:0] ty;
    logic [rtsp_pkg::WORLD_W-1:0] dx_raw;
    logic [rtsp_pkg::WORLD_W-1:0] dy_raw;
    logic                         is_init;
    logic [rtsp_pkg::VIEW_W-1:0]  rc_fin;
    logic [rtsp_pkg::VIEW_W-1:0]  rr_fin;
    logic [rtsp_pkg::STEP_W-1:0]  steps;

    assign item_ready = !q_full;
    assign q_push     = item_valid && !q_full;

    always_comb
    begin
        // Floor division by the tile size, then centre the camera tile.
        cx_div  = 32'(item.cam_x) >>> 3;
        cy_div  = 32'(item.cam_y) >>> 3;
        tx      = rtsp_pkg::WORLD_W'(cx_div - rtsp_pkg::CENTER_TILES);
        ty      = rtsp_pkg::WORLD_W'(cy_div - rtsp_pkg::CENTER_TILES);
        dx_raw  = tx - origin_x_reg;
        dy_raw  = ty - origin_y_reg;
        is_init = (rtsp_pkg::cmd_t'(item.command) == rtsp_pkg::CMD_INIT);

        q_job.is_init = is_init;
        q_job.ox0     = origin_x_reg;
        q_job.oy0     = origin_y_reg;
        q_job.rc0     = ring_col_reg;
        q_job.rr0     = ring_row_reg;
        q_job.tx      = tx;
        q_job.ty      = ty;

        // The top bit of the modular delta marks the backward half of the world.
        q_job.col_neg = dx_raw[rtsp_pkg::WORLD_W-1];
        q_job.row_neg = dy_raw[rtsp_pkg::WORLD_W-1];
        q_job.col_mag = dx_raw[rtsp_pkg::WORLD_W-1] ?
                        (rtsp_pkg::WORLD_W'(0) - dx_raw) : dx_raw;
        q_job.row_mag = dy_raw[rtsp_pkg::WORLD_W-1] ?
                        (rtsp_pkg::WORLD_W'(0) - dy_raw) : dy_raw;

        // The ring moves by the same signed delta, taken modulo the ring size; an init command resets it to zero.
        rc_fin = is_init ? '0 : ring_col_reg + dx_raw[rtsp_pkg::VIEW_W-1:0];
        rr_fin = is_init ? '0 : ring_row_reg + dy_raw[rtsp_pkg::VIEW_W-1:0];
        q_job.rc_fin = rc_fin;
        q_job.rr_fin = rr_fin;

        q_job.scroll_x = 16'({rc_fin, 3'b000}) + 16'(item.cam_x) - 16'({tx, 3'b000});
        q_job.scroll_y = 16'({rr_fin, 3'b000}) + 16'(item.cam_y) - 16'({ty, 3'b000});

        steps = {1'b0, q_job.col_mag} + {1'b0, q_job.row_mag};
        if (is_init)
        begin
            q_job.dropped = 1'b0;
            q_job.total   = rtsp_pkg::CNT_W'(1);
        end
        else if (steps > rtsp_pkg::STEP_W'(rtsp_pkg::UPDATE_LIMIT))
        begin
            q_job.dropped = 1'b1;
            q_job.total   = rtsp_pkg::CNT_W'(rtsp_pkg::UPDATE_LIMIT);
        end
        else
        begin
            q_job.dropped = 1'b0;
            q_job.total   = (steps == '0) ? rtsp_pkg::CNT_W'(1) : rtsp_pkg::CNT_W'(steps);
        end

        origin_x_next = q_push ? tx : origin_x_reg;
        origin_y_next = q_push ? ty : origin_y_reg;
        ring_col_next = q_push ? rc_fin : ring_col_reg;
        ring_row_next = q_push ? rr_fin : ring_row_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            ring_col_reg <= '0;
            ring_row_reg <= '0;
        end
        else
        begin
            origin_x_reg <= origin_x_next;
            origin_y_reg <= origin_y_next;
            ring_col_reg <= ring_col_next;
            ring_row_reg <= ring_row_next;
        end
    end

endmodule

### design/rtsp_queue.sv
// ----------------------------------------------------------------------------
// rtsp_queue
// Short first-in first-out queue of jobs between the front and the back.
// ----------------------------------------------------------------------------
module rtsp_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  rtsp_pkg::job_t push_job,
    input  logic           pop,
    output rtsp_pkg::job_t head_job,
    output logic           full,
    output logic           empty
);

    rtsp_pkg::job_t              mem [rtsp_pkg::QUEUE_DEPTH];
    logic [rtsp_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [rtsp_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [rtsp_pkg::QCNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == rtsp_pkg::QCNT_W'(rtsp_pkg::QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign head_job = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == rtsp_pkg::QPTR_W'(rtsp_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == rtsp_pkg::QPTR_W'(rtsp_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### design/rtsp_back.sv
// ----------------------------------------------------------------------------
// rtsp_back
// Takes one job at a time and walks its column then row steps, one refill
// word per cycle while the output is free, into an output register.
// ----------------------------------------------------------------------------
module rtsp_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  rtsp_pkg::job_t    q_head,
    output logic              q_pop,
    output logic              result_valid,
    input  logic              result_ready,
    output rtsp_pkg::result_t result
);

    rtsp_pkg::bk_state_t          state_reg, state_next;
    rtsp_pkg::job_t               job_reg, job_next;
    logic [rtsp_pkg::WORLD_W-1:0] cur_ox_reg, cur_ox_next;
    logic [rtsp_pkg::WORLD_W-1:0] cur_oy_reg, cur_oy_next;
    logic [rtsp_pkg::VIEW_W-1:0]  cur_rc_reg, cur_rc_next;
    logic [rtsp_pkg::VIEW_W-1:0]  cur_rr_reg, cur_rr_next;
    logic [rtsp_pkg::WORLD_W-1:0] col_rem_reg, col_rem_next;
    logic [rtsp_pkg::WORLD_W-1:0] row_rem_reg, row_rem_next;
    logic [rtsp_pkg::CNT_W-1:0]   sent_reg, sent_next;
    logic                         out_valid_reg, out_valid_next;
    rtsp_pkg::result_t            out_reg, out_next;

    logic                         out_free;
    logic                         single;
    logic                         is_last;
    logic [rtsp_pkg::WORLD_W-1:0] step_o;
    logic [rtsp_pkg::VIEW_W-1:0]  step_r;

    assign result_valid = out_valid_reg;
    assign result       = out_reg;
    assign out_free     = !out_valid_reg || result_ready;

    always_comb
    begin
        state_next     = state_reg;
        job_next       = job_reg;
        cur_ox_next    = cur_ox_reg;
        cur_oy_next    = cur_oy_reg;
        cur_rc_next    = cur_rc_reg;
        cur_rr_next    = cur_rr_reg;
        col_rem_next   = col_rem_reg;
        row_rem_next   = row_rem_reg;
        sent_next      = sent_reg;
        out_valid_next = out_valid_reg && !result_ready;
        out_next       = out_reg;
        q_pop          = 1'b0;
        step_o         = '0;
        step_r         = '0;

        single  = job_reg.is_init || ((job_reg.col_mag == '0) && (job_reg.row_mag == '0));
        is_last = single || (rtsp_pkg::CNT_W'(sent_reg + 1'b1) == job_reg.total);

        case (state_reg)
            rtsp_pkg::BK_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop        = 1'b1;
                    job_next     = q_head;
                    cur_ox_next  = q_head.ox0;
                    cur_oy_next  = q_head.oy0;
                    cur_rc_next  = q_head.rc0;
                    cur_rr_next  = q_head.rr0;
                    col_rem_next = q_head.col_mag;
                    row_rem_next = q_head.row_mag;
                    sent_next    = '0;
                    state_next   = rtsp_pkg::BK_RUN;
                end
            end
            rtsp_pkg::BK_RUN:
            begin
                if (out_free)
                begin
                    out_next.scroll_x  = job_reg.scroll_x;
                    out_next.scroll_y  = job_reg.scroll_y;
                    out_next.ring_left = job_reg.rc_fin;
                    out_next.ring_top  = job_reg.rr_fin;
                    out_next.last      = is_last;
                    out_next.dropped   = is_last && job_reg.dropped;

                    if (single)
                    begin
                        out_next.update_kind = job_reg.is_init ? rtsp_pkg::KIND_RELOAD
                                                               : rtsp_pkg::KIND_NONE;
                        out_next.vram_line   = '0;
                        out_next.src_x       = job_reg.tx;
                        out_next.src_y       = job_reg.ty;
                    end
                    else if (col_rem_reg != '0)
                    begin
                        // Columns go first; the row origin is still the old one.
                        out_next.update_kind = rtsp_pkg::KIND_COL;
                        out_next.src_y       = job_reg.oy0;
                        if (job_reg.col_neg)
                        begin
                            step_o             = cur_ox_reg - 1'b1;
                            step_r             = cur_rc_reg - 1'b1;
                            out_next.vram_line = step_r;
                            out_next.src_x     = step_o;
                        end
                        else
                        begin
                            step_o             = cur_ox_reg + 1'b1;
                            step_r             = cur_rc_reg + 1'b1;
                            out_next.vram_line = cur_rc_reg;
                            out_next.src_x     = step_o +
                                                 rtsp_pkg::WORLD_W'(rtsp_pkg::VIEW_TILES - 1);
                        end
                        cur_ox_next  = step_o;
                        cur_rc_next  = step_r;
                        col_rem_next = col_rem_reg - 1'b1;
                    end
                    else
                    begin
                        out_next.update_kind = rtsp_pkg::KIND_ROW;
                        out_next.src_x       = job_reg.tx;
                        if (job_reg.row_neg)
                        begin
                            step_o             = cur_oy_reg - 1'b1;
                            step_r             = cur_rr_reg - 1'b1;
                            out_next.vram_line = step_r;
                            out_next.src_y     = step_o;
                        end
                        else
                        begin
                            step_o             = cur_oy_reg + 1'b1;
                            step_r             = cur_rr_reg + 1'b1;
                            out_next.vram_line = cur_rr_reg;
                            out_next.src_y     = step_o +
                                                 rtsp_pkg::WORLD_W'(rtsp_pkg::VIEW_TILES - 1);
                        end
                        cur_oy_next  = step_o;
                        cur_rr_next  = step_r;
                        row_rem_next = row_rem_reg - 1'b1;
                    end

                    out_valid_next = 1'b1;
                    sent_next      = rtsp_pkg::CNT_W'(sent_reg + 1'b1);
                    if (is_last)
                    begin
                        state_next = rtsp_pkg::BK_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = rtsp_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rtsp_pkg::BK_IDLE;
            out_valid_reg <= 1'b0;
            sent_reg      <= '0;
            col_rem_reg   <= '0;
            row_rem_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            sent_reg      <= sent_next;
            col_rem_reg   <= col_rem_next;
            row_rem_reg   <= row_rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg    <= job_next;
        cur_ox_reg <= cur_ox_next;
        cur_oy_reg <= cur_oy_next;
        cur_rc_reg <= cur_rc_next;
        cur_rr_reg <= cur_rr_next;
        out_reg    <= out_next;
    end

endmodule
